// ===== rtl/tcc_pkg.sv =====
package tcc_pkg;

    localparam int W_IN       = 32;
    localparam int W_TD_IN    = 6 * W_IN;
    localparam int W_TD_OUT   = 3 * W_IN;
    localparam int W_TU_OUT   = 2;

    localparam int W_DIF      = W_IN + 1;
    localparam int W_HALF     = W_DIF;
    localparam int W_SQ       = 2 * W_DIF;
    localparam int W_DET      = W_SQ + 1;
    localparam int W_NRM      = W_SQ;
    localparam int W_DMAG     = W_SQ;
    localparam int W_PP       = W_DIF + W_HALF + 1;
    localparam int W_DLO      = W_DET - W_HALF;
    localparam int W_DXA      = W_HALF + W_IN;
    localparam int W_NUM      = 100;
    localparam int W_FULL     = W_NUM + 1;
    localparam int W_TOP      = W_FULL;
    localparam int W_DEN      = W_DMAG + 1;
    localparam int W_CQ       = W_IN;

    localparam int W_BC       = 2 * W_NRM;
    localparam int W_T        = W_BC + W_HALF;
    localparam int W_P        = 3 * W_NRM;
    localparam int W_DSQ      = 2 * W_DMAG;
    localparam int W_RQ       = W_NRM;
    localparam int W_ROOT     = W_RQ / 2;
    localparam int W_SREM     = W_ROOT + 3;

    localparam int N_CDIV     = W_CQ;
    localparam int N_RDIV     = W_RQ;
    localparam int N_SQRT     = W_ROOT;
    localparam int T_CFIN     = N_CDIV + 1;
    localparam int T_SQ0      = N_RDIV + 1;
    localparam int N_TAIL     = N_RDIV + N_SQRT + 1;
    localparam int N_FRONT    = 8;

    localparam logic [W_CQ-1:0] C_LIM_POS = {1'b0, {(W_CQ-1){1'b1}}};
    localparam logic [W_CQ-1:0] C_LIM_NEG = {1'b1, {(W_CQ-1){1'b0}}};

endpackage

// ===== rtl/triangle_circumcircle_top.sv =====
// circumcircle of a triangle, one triangle per transfer
//
// slave channel: six signed q16.16 coordinates (x1, y1, x2, y2, x3, y3) in
// tdata. master channel: center x, center y and radius in tdata, and the
// degenerate and overflow flags in tuser.
//
// the datapath is a fixed pipeline: the product and sum stages, one
// range check stage, a restoring divider that makes one quotient bit per
// stage (66 stages for the squared radius, 32 for each center axis side by
// side), 33 square root stages and the output register, 109 stages in all.
// one triangle is taken every cycle while the receiver does not stall.
//
// collinear or repeated points give zeros with the degenerate flag. a
// saturated result sets the overflow flag.
//
// reset clears all valid bits; the pipeline is empty after it. when the
// receiver stalls, the whole pipeline holds and tready drops until the
// waiting result is taken; nothing is lost or repeated.
module triangle_circumcircle_top
    import tcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y
    input  logic [W_TD_IN-1:0]  i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // center_x, center_y, radius
    output logic [W_TD_OUT-1:0] o_m_axis_tdata,
    // degenerate, overflow
    output logic [W_TU_OUT-1:0] o_m_axis_tuser
);

    function automatic logic [W_TOP:0] f_cstep(input logic [W_TOP-1:0] rem,
                                               input logic [W_TOP-1:0] sh);
        logic ge;
        ge = rem >= sh;
        f_cstep = {ge, ge ? rem - sh : rem};
    endfunction

    function automatic logic [W_CQ:0] f_csat(input logic [W_CQ-1:0] q,
                                             input logic neg, input logic ovf);
        logic [W_CQ-1:0] lim;
        logic            sat;
        logic [W_CQ-1:0] mag;
        lim = neg ? C_LIM_NEG : C_LIM_POS;
        sat = ovf || (q > lim);
        mag = sat ? lim : q;
        f_csat = {sat, neg ? (W_CQ'(0) - mag) : mag};
    endfunction

    logic c_en;
    logic r_out_vld;
    logic [W_TD_OUT-1:0] r_out_data;
    logic [W_TU_OUT-1:0] r_out_user;

    assign c_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = c_en;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    logic signed [W_IN-1:0] c_x1, c_y1, c_x2, c_y2, c_x3, c_y3;
    assign c_x1 = i_s_axis_tdata[0*W_IN +: W_IN];
    assign c_y1 = i_s_axis_tdata[1*W_IN +: W_IN];
    assign c_x2 = i_s_axis_tdata[2*W_IN +: W_IN];
    assign c_y2 = i_s_axis_tdata[3*W_IN +: W_IN];
    assign c_x3 = i_s_axis_tdata[4*W_IN +: W_IN];
    assign c_y3 = i_s_axis_tdata[5*W_IN +: W_IN];

    logic [N_FRONT-1:0] r_vf;
    logic [N_TAIL-1:0]  r_vt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf      <= '0;
            r_vt      <= '0;
            r_out_vld <= 1'b0;
        end else if (c_en) begin
            r_vf      <= {r_vf[N_FRONT-2:0], i_s_axis_tvalid};
            r_vt      <= {r_vt[N_TAIL-2:0], r_vf[N_FRONT-1]};
            r_out_vld <= r_vt[N_TAIL-1];
        end
    end

    // stage 1: differences
    logic signed [W_IN-1:0]  r1_x1, r1_y1;
    logic signed [W_DIF-1:0] r1_ux, r1_uy, r1_vx, r1_vy, r1_wx, r1_wy;

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r1_x1 <= c_x1;
            r1_y1 <= c_y1;
            r1_ux <= W_DIF'(c_x2) - W_DIF'(c_x1);
            r1_uy <= W_DIF'(c_y2) - W_DIF'(c_y1);
            r1_vx <= W_DIF'(c_x3) - W_DIF'(c_x1);
            r1_vy <= W_DIF'(c_y3) - W_DIF'(c_y1);
            r1_wx <= W_DIF'(c_x3) - W_DIF'(c_x2);
            r1_wy <= W_DIF'(c_y3) - W_DIF'(c_y2);
        end
    end

    // stage 2: cross products and squares
    logic signed [W_IN-1:0]  r2_x1, r2_y1;
    logic signed [W_DIF-1:0] r2_ux, r2_uy, r2_vx, r2_vy;
    logic signed [W_SQ-1:0]  r2_puv, r2_pvu, r2_sux, r2_suy, r2_svx, r2_svy, r2_swx, r2_swy;

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r2_x1  <= r1_x1;
            r2_y1  <= r1_y1;
            r2_ux  <= r1_ux;
            r2_uy  <= r1_uy;
            r2_vx  <= r1_vx;
            r2_vy  <= r1_vy;
            r2_puv <= r1_ux * r1_vy;
            r2_pvu <= r1_uy * r1_vx;
            r2_sux <= r1_ux * r1_ux;
            r2_suy <= r1_uy * r1_uy;
            r2_svx <= r1_vx * r1_vx;
            r2_svy <= r1_vy * r1_vy;
            r2_swx <= r1_wx * r1_wx;
            r2_swy <= r1_wy * r1_wy;
        end
    end

    // stage 3: determinant and squared side lengths
    logic signed [W_IN-1:0]  r3_x1, r3_y1;
    logic signed [W_DIF-1:0] r3_ux, r3_uy, r3_vx, r3_vy;
    logic signed [W_DET-1:0] r3_det;
    logic [W_NRM-1:0]        r3_b, r3_c, r3_e;

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r3_x1  <= r2_x1;
            r3_y1  <= r2_y1;
            r3_ux  <= r2_ux;
            r3_uy  <= r2_uy;
            r3_vx  <= r2_vx;
            r3_vy  <= r2_vy;
            r3_det <= W_DET'(r2_puv) - W_DET'(r2_pvu);
            r3_b   <= W_NRM'(r2_sux + r2_suy);
            r3_c   <= W_NRM'(r2_svx + r2_svy);
            r3_e   <= W_NRM'(r2_swx + r2_swy);
        end
    end

    // stage 4: partial products
    logic signed [W_PP-1:0]  r4_nxa, r4_nxb, r4_nxc, r4_nxd, r4_nya, r4_nyb, r4_nyc, r4_nyd;
    logic signed [W_DXA-1:0] r4_dxa, r4_dya;
    logic signed [W_PP-1:0]  r4_dxb, r4_dyb;
    logic [W_SQ-1:0]         r4_bcll, r4_bclh, r4_bchl, r4_bchh;
    logic [W_NRM-1:0]        r4_e;
    logic [W_DMAG-1:0]       r4_dmag;
    logic                    r4_dneg, r4_dg;
    logic signed [W_HALF:0]  c4_blo, c4_bhi, c4_clo, c4_chi;
    logic signed [W_DLO:0]   c4_dlo;
    logic signed [W_HALF-1:0] c4_dhi;

    assign c4_blo = $signed({1'b0, r3_b[W_HALF-1:0]});
    assign c4_bhi = $signed({1'b0, r3_b[W_NRM-1:W_HALF]});
    assign c4_clo = $signed({1'b0, r3_c[W_HALF-1:0]});
    assign c4_chi = $signed({1'b0, r3_c[W_NRM-1:W_HALF]});
    assign c4_dlo = $signed({1'b0, r3_det[W_DLO-1:0]});
    assign c4_dhi = $signed(r3_det[W_DET-1:W_DLO]);

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r4_nxa  <= r3_vy * c4_bhi;
            r4_nxb  <= r3_vy * c4_blo;
            r4_nxc  <= r3_uy * c4_chi;
            r4_nxd  <= r3_uy * c4_clo;
            r4_nya  <= r3_ux * c4_chi;
            r4_nyb  <= r3_ux * c4_clo;
            r4_nyc  <= r3_vx * c4_bhi;
            r4_nyd  <= r3_vx * c4_blo;
            r4_dxa  <= c4_dhi * r3_x1;
            r4_dxb  <= c4_dlo * r3_x1;
            r4_dya  <= c4_dhi * r3_y1;
            r4_dyb  <= c4_dlo * r3_y1;
            r4_bcll <= r3_b[W_HALF-1:0] * r3_c[W_HALF-1:0];
            r4_bclh <= r3_b[W_HALF-1:0] * r3_c[W_NRM-1:W_HALF];
            r4_bchl <= r3_b[W_NRM-1:W_HALF] * r3_c[W_HALF-1:0];
            r4_bchh <= r3_b[W_NRM-1:W_HALF] * r3_c[W_NRM-1:W_HALF];
            r4_e    <= r3_e;
            r4_dneg <= r3_det[W_DET-1];
            r4_dmag <= r3_det[W_DET-1] ? W_DMAG'(-r3_det) : W_DMAG'(r3_det);
            r4_dg   <= (r3_det == '0);
        end
    end

    // stage 5: numerators, base terms, b*c, determinant square partials
    logic signed [W_NUM-1:0] r5_nx, r5_ny, r5_dx, r5_dy;
    logic [W_BC-1:0]         r5_bc;
    logic [W_NRM-1:0]        r5_e;
    logic [W_DMAG-1:0]       r5_dmag;
    logic                    r5_dneg, r5_dg;
    logic [W_SQ-1:0]         r5_ddll, r5_ddlh, r5_ddhh;

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r5_nx   <= (W_NUM'(r4_nxa) << W_HALF) + W_NUM'(r4_nxb)
                     - (W_NUM'(r4_nxc) << W_HALF) - W_NUM'(r4_nxd);
            r5_ny   <= (W_NUM'(r4_nya) << W_HALF) + W_NUM'(r4_nyb)
                     - (W_NUM'(r4_nyc) << W_HALF) - W_NUM'(r4_nyd);
            r5_dx   <= (W_NUM'(r4_dxa) << W_DLO) + W_NUM'(r4_dxb);
            r5_dy   <= (W_NUM'(r4_dya) << W_DLO) + W_NUM'(r4_dyb);
            r5_bc   <= W_BC'(r4_bcll) + (W_BC'(r4_bclh) << W_HALF)
                     + (W_BC'(r4_bchl) << W_HALF) + (W_BC'(r4_bchh) << (2 * W_HALF));
            r5_e    <= r4_e;
            r5_dmag <= r4_dmag;
            r5_dneg <= r4_dneg;
            r5_dg   <= r4_dg;
            r5_ddll <= r4_dmag[W_HALF-1:0] * r4_dmag[W_HALF-1:0];
            r5_ddlh <= r4_dmag[W_HALF-1:0] * r4_dmag[W_DMAG-1:W_HALF];
            r5_ddhh <= r4_dmag[W_DMAG-1:W_HALF] * r4_dmag[W_DMAG-1:W_HALF];
        end
    end

    // stage 6: full numerators, b*c*e partials, determinant square
    logic signed [W_FULL-1:0] r6_fx, r6_fy;
    logic [W_SQ-1:0]          r6_pe0 [4];
    logic [W_SQ-1:0]          r6_pe1 [4];
    logic [W_DSQ-1:0]         r6_dsq;
    logic [W_DMAG-1:0]        r6_dmag;
    logic                     r6_dneg, r6_dg;

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r6_fx   <= W_FULL'(r5_nx) + (W_FULL'(r5_dx) << 1);
            r6_fy   <= W_FULL'(r5_ny) + (W_FULL'(r5_dy) << 1);
            for (int j = 0; j < 4; j++) begin
                r6_pe0[j] <= r5_bc[W_HALF*j +: W_HALF] * r5_e[W_HALF-1:0];
                r6_pe1[j] <= r5_bc[W_HALF*j +: W_HALF] * r5_e[W_NRM-1:W_HALF];
            end
            r6_dsq  <= W_DSQ'(r5_ddll) + (W_DSQ'(r5_ddlh) << (W_HALF + 1))
                     + (W_DSQ'(r5_ddhh) << (2 * W_HALF));
            r6_dmag <= r5_dmag;
            r6_dneg <= r5_dneg;
            r6_dg   <= r5_dg;
        end
    end

    // stage 7: rounding dividends, partial sums of b*c*e
    logic [W_FULL-1:0] n7_fxmag, n7_fymag;
    logic [W_T-1:0]    n7_t0, n7_t1;
    logic [W_TOP-1:0]  r7_topx, r7_topy;
    logic              r7_negx, r7_negy, r7_dg;
    logic [W_DEN-1:0]  r7_den;
    logic [W_T-1:0]    r7_t0, r7_t1;
    logic [W_DSQ-1:0]  r7_dsq;

    always_comb begin
        n7_fxmag = r6_fx[W_FULL-1] ? W_FULL'(-r6_fx) : W_FULL'(r6_fx);
        n7_fymag = r6_fy[W_FULL-1] ? W_FULL'(-r6_fy) : W_FULL'(r6_fy);
        n7_t0 = '0;
        n7_t1 = '0;
        for (int j = 0; j < 4; j++) begin
            n7_t0 = n7_t0 + (W_T'(r6_pe0[j]) << (W_HALF * j));
            n7_t1 = n7_t1 + (W_T'(r6_pe1[j]) << (W_HALF * j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r7_topx <= W_TOP'(n7_fxmag) + W_TOP'(r6_dmag);
            r7_topy <= W_TOP'(n7_fymag) + W_TOP'(r6_dmag);
            r7_negx <= r6_fx[W_FULL-1] != r6_dneg;
            r7_negy <= r6_fy[W_FULL-1] != r6_dneg;
            r7_den  <= {r6_dmag, 1'b0};
            r7_t0   <= n7_t0;
            r7_t1   <= n7_t1;
            r7_dsq  <= r6_dsq;
            r7_dg   <= r6_dg;
        end
    end

    // stage 8: b*c*e
    logic [W_TOP-1:0] r8_topx, r8_topy;
    logic             r8_negx, r8_negy, r8_dg;
    logic [W_DEN-1:0] r8_den;
    logic [W_P-1:0]   r8_p;
    logic [W_DSQ-1:0] r8_dsq;

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r8_topx <= r7_topx;
            r8_topy <= r7_topy;
            r8_negx <= r7_negx;
            r8_negy <= r7_negy;
            r8_den  <= r7_den;
            r8_p    <= W_P'(r7_t0) + (W_P'(r7_t1) << W_HALF);
            r8_dsq  <= r7_dsq;
            r8_dg   <= r7_dg;
        end
    end

    // division and square root chain
    logic [W_P-1:0]    r_rrem  [0:N_RDIV];
    logic [W_DSQ-1:0]  r_rdsq  [0:N_RDIV];
    logic [W_RQ-1:0]   r_rq    [0:N_TAIL-1];
    logic              r_rovf  [0:N_TAIL-1];
    logic [W_SREM-1:0] r_srem  [T_SQ0:N_TAIL-1];
    logic [W_ROOT-1:0] r_sroot [T_SQ0:N_TAIL-1];
    logic [W_TOP-1:0]  r_crx   [0:N_CDIV];
    logic [W_TOP-1:0]  r_cry   [0:N_CDIV];
    logic [W_DEN-1:0]  r_cden  [0:N_CDIV];
    logic [W_CQ-1:0]   r_cqx   [0:N_CDIV];
    logic [W_CQ-1:0]   r_cqy   [0:N_CDIV];
    logic              r_cnegx [0:N_CDIV];
    logic              r_cnegy [0:N_CDIV];
    logic              r_covfx [0:N_CDIV];
    logic              r_covfy [0:N_CDIV];
    logic [W_IN-1:0]   r_cx    [T_CFIN:N_TAIL-1];
    logic [W_IN-1:0]   r_cy    [T_CFIN:N_TAIL-1];
    logic              r_cov   [T_CFIN:N_TAIL-1];
    logic              r_dg    [0:N_TAIL-1];

    // range checks ahead of the quotient bits
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_rrem[0]  <= r8_p;
            r_rdsq[0]  <= r8_dsq;
            r_rq[0]    <= '0;
            r_rovf[0]  <= r8_p >= (W_P'(r8_dsq) << N_RDIV);
            r_crx[0]   <= r8_topx;
            r_cry[0]   <= r8_topy;
            r_cden[0]  <= r8_den;
            r_cqx[0]   <= '0;
            r_cqy[0]   <= '0;
            r_cnegx[0] <= r8_negx;
            r_cnegy[0] <= r8_negy;
            r_covfx[0] <= r8_topx >= (W_TOP'(r8_den) << N_CDIV);
            r_covfy[0] <= r8_topy >= (W_TOP'(r8_den) << N_CDIV);
            r_dg[0]    <= r8_dg;
        end
    end

    for (genvar k = 1; k < N_TAIL; k++) begin : g_tail
        always_ff @(posedge i_clk) begin
            if (c_en) begin
                r_dg[k] <= r_dg[k-1];
            end
        end

        if (k <= N_RDIV) begin : g_rdiv
            logic [W_P-1:0]  n_sh;
            logic            n_ge;
            logic [W_RQ-1:0] n_q;
            always_comb begin
                n_sh = W_P'(r_rdsq[k-1]) << (N_RDIV - k);
                n_ge = r_rrem[k-1] >= n_sh;
                n_q  = r_rq[k-1];
                n_q[N_RDIV-k] = n_ge;
            end
            always_ff @(posedge i_clk) begin
                if (c_en) begin
                    r_rrem[k] <= n_ge ? r_rrem[k-1] - n_sh : r_rrem[k-1];
                    r_rdsq[k] <= r_rdsq[k-1];
                    r_rq[k]   <= n_q;
                    r_rovf[k] <= r_rovf[k-1];
                end
            end
        end else begin : g_rhold
            always_ff @(posedge i_clk) begin
                if (c_en) begin
                    r_rq[k]   <= r_rq[k-1];
                    r_rovf[k] <= r_rovf[k-1];
                end
            end
        end

        if (k >= T_SQ0) begin : g_sqrt
            localparam int BI = N_SQRT - 1 - (k - T_SQ0);
            logic [W_SREM-1:0] n_prem;
            logic [W_ROOT-1:0] n_proot;
            logic [W_SREM-1:0] n_rsh;
            logic [W_SREM-1:0] n_trial;
            logic              n_ge;
            if (k == T_SQ0) begin : g_first
                assign n_prem  = '0;
                assign n_proot = '0;
            end else begin : g_next
                assign n_prem  = r_srem[k-1];
                assign n_proot = r_sroot[k-1];
            end
            always_comb begin
                n_rsh   = {n_prem[W_SREM-3:0], r_rq[k-1][2*BI+1 -: 2]};
                n_trial = {{(W_SREM-W_ROOT-2){1'b0}}, n_proot, 2'b01};
                n_ge    = n_rsh >= n_trial;
            end
            always_ff @(posedge i_clk) begin
                if (c_en) begin
                    r_srem[k]  <= n_ge ? n_rsh - n_trial : n_rsh;
                    r_sroot[k] <= {n_proot[W_ROOT-2:0], n_ge};
                end
            end
        end

        if (k <= N_CDIV) begin : g_cdiv
            logic [W_TOP-1:0] n_sh;
            logic [W_TOP:0]   n_sx, n_sy;
            always_comb begin
                n_sh = W_TOP'(r_cden[k-1]) << (N_CDIV - k);
                n_sx = f_cstep(r_crx[k-1], n_sh);
                n_sy = f_cstep(r_cry[k-1], n_sh);
            end
            always_ff @(posedge i_clk) begin
                if (c_en) begin
                    r_crx[k]   <= n_sx[W_TOP-1:0];
                    r_cry[k]   <= n_sy[W_TOP-1:0];
                    r_cden[k]  <= r_cden[k-1];
                    r_cqx[k]   <= {r_cqx[k-1][W_CQ-2:0], n_sx[W_TOP]};
                    r_cqy[k]   <= {r_cqy[k-1][W_CQ-2:0], n_sy[W_TOP]};
                    r_cnegx[k] <= r_cnegx[k-1];
                    r_cnegy[k] <= r_cnegy[k-1];
                    r_covfx[k] <= r_covfx[k-1];
                    r_covfy[k] <= r_covfy[k-1];
                end
            end
        end else if (k == T_CFIN) begin : g_cfin
            logic [W_CQ:0] n_fx, n_fy;
            always_comb begin
                n_fx = f_csat(r_cqx[k-1], r_cnegx[k-1], r_covfx[k-1]);
                n_fy = f_csat(r_cqy[k-1], r_cnegy[k-1], r_covfy[k-1]);
            end
            always_ff @(posedge i_clk) begin
                if (c_en) begin
                    r_cx[k]  <= n_fx[W_CQ-1:0];
                    r_cy[k]  <= n_fy[W_CQ-1:0];
                    r_cov[k] <= n_fx[W_CQ] || n_fy[W_CQ];
                end
            end
        end else begin : g_chold
            always_ff @(posedge i_clk) begin
                if (c_en) begin
                    r_cx[k]  <= r_cx[k-1];
                    r_cy[k]  <= r_cy[k-1];
                    r_cov[k] <= r_cov[k-1];
                end
            end
        end
    end

    // radius = (root + 1) / 2, then output register
    logic [W_ROOT:0]   c_rsum;
    logic [W_ROOT-1:0] c_rr;
    logic              c_rsat;
    logic [W_IN-1:0]   c_rad;

    always_comb begin
        c_rsum = {1'b0, r_sroot[N_TAIL-1]} + 1'b1;
        c_rr   = c_rsum[W_ROOT:1];
        c_rsat = r_rovf[N_TAIL-1] || c_rr[W_ROOT-1];
        c_rad  = c_rsat ? '1 : c_rr[W_IN-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            if (r_dg[N_TAIL-1]) begin
                r_out_data <= '0;
                r_out_user <= 2'b01;
            end else begin
                r_out_data <= {c_rad, r_cy[N_TAIL-1], r_cx[N_TAIL-1]};
                r_out_user <= {r_cov[N_TAIL-1] || c_rsat, 1'b0};
            end
        end
    end

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |->
            (o_m_axis_tdata == '0 && !o_m_axis_tuser[1]))
        else $error("degenerate result carries nonzero data or overflow");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !c_en |=> ($stable(r_vt) && $stable(r_vf)))
        else $error("pipeline moved during a stall");

    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vt[N_TAIL-1] |->
            (r_srem[N_TAIL-1] <= (W_SREM'(r_sroot[N_TAIL-1]) << 1)))
        else $error("square root remainder out of bound");

endmodule

// ===== dv/tb_triangle_circumcircle_top.sv =====
module tb_triangle_circumcircle_top
    import tcc_pkg::*;
();

    typedef struct packed {
        logic [31:0] center_x;
        logic [31:0] center_y;
        logic [31:0] radius;
        logic        degenerate;
        logic        overflow;
    } t_circle;

    class t_circle_scoreboard;
        t_circle expected_q[$];
        int      mismatches;

        function logic [31:0] round_axis(logic signed [255:0] num, logic signed [255:0] det,
                                         logic signed [255:0] base, inout logic ovf);
            logic signed [255:0] full;
            logic [255:0]        full_mag;
            logic [255:0]        det_mag;
            logic [255:0]        quot;
            logic [255:0]        lim;
            logic                neg;
            full     = num + 2 * det * base;
            full_mag = full < 0 ? -full : full;
            det_mag  = det < 0 ? -det : det;
            quot     = (full_mag + det_mag) / (2 * det_mag);
            neg      = (full < 0) != (det < 0);
            lim      = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
            if (quot > lim) begin
                quot = lim;
                ovf  = 1'b1;
            end
            round_axis = neg ? 32'(-quot) : quot[31:0];
        endfunction

        function void note_triangle(logic [W_TD_IN-1:0] d);
            logic signed [255:0] x1, y1, x2, y2, x3, y3;
            logic signed [255:0] ux, uy, vx, vy, wx, wy, det, b2, c2, e2, nx, ny;
            logic [511:0]        prod, dsq, dmag, lhs, k;
            logic [31:0]         r, t;
            t_circle             res;
            x1 = $signed(d[31:0]);    y1 = $signed(d[63:32]);
            x2 = $signed(d[95:64]);   y2 = $signed(d[127:96]);
            x3 = $signed(d[159:128]); y3 = $signed(d[191:160]);
            ux = x2 - x1; uy = y2 - y1;
            vx = x3 - x1; vy = y3 - y1;
            wx = x3 - x2; wy = y3 - y2;
            det = ux * vy - uy * vx;
            res = '0;
            if (det == 0) begin
                res.degenerate = 1'b1;
                expected_q = {expected_q, res};
                return;
            end
            b2 = ux * ux + uy * uy;
            c2 = vx * vx + vy * vy;
            e2 = wx * wx + wy * wy;
            nx = vy * b2 - uy * c2;
            ny = ux * c2 - vx * b2;
            res.center_x = round_axis(nx, det, x1, res.overflow);
            res.center_y = round_axis(ny, det, y1, res.overflow);
            // largest r with (2r-1)^2 * det^2 <= b2*c2*e2
            prod = 512'(b2) * 512'(c2) * 512'(e2);
            dmag = det < 0 ? 512'(-det) : 512'(det);
            dsq  = dmag * dmag;
            k    = 512'h1_FFFF_FFFF;
            r    = '0;
            if (k * k * dsq <= prod) begin
                r = '1;
                res.overflow = 1'b1;
            end else begin
                for (int b = 31; b >= 0; b--) begin
                    t   = r | (32'd1 << b);
                    k   = 2 * 512'(t) - 1;
                    lhs = k * k * dsq;
                    if (lhs <= prod) r = t;
                end
            end
            res.radius = r;
            expected_q = {expected_q, res};
        endfunction

        function void check_circle(logic [W_TD_OUT-1:0] d, logic [W_TU_OUT-1:0] u);
            t_circle got;
            t_circle want;
            got = {d[31:0], d[63:32], d[95:64], u[0], u[1]};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = expected_q.pop_front();
            if (got.center_x !== want.center_x || got.center_y !== want.center_y ||
                got.radius !== want.radius || got.degenerate !== want.degenerate ||
                got.overflow !== want.overflow) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp cx=%h cy=%h r=%h deg=%b ovf=%b",
                             want.center_x, want.center_y, want.radius, want.degenerate,
                             want.overflow,
                             " got cx=%h cy=%h r=%h deg=%b ovf=%b",
                             got.center_x, got.center_y, got.radius,
                             got.degenerate, got.overflow);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                s_valid;
    logic                s_ready;
    logic [W_TD_IN-1:0]  s_data;
    logic                m_valid;
    logic                m_ready;
    logic [W_TD_OUT-1:0] m_data;
    logic [W_TU_OUT-1:0] m_user;

    t_circle_scoreboard sb;
    logic             hold_active;
    logic             burst_mode;
    int               results_seen;
    int               idle_cycles;

    triangle_circumcircle_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function int draw_gap();
        if (burst_mode || hold_active) return 0;
        return $urandom_range(0, 16);
    endfunction

    task automatic send_triangle(logic [W_TD_IN-1:0] d);
        int  gap;
        bit  acc;
        gap = draw_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do begin
            @(negedge i_clk);
            acc = s_ready;
            @(posedge i_clk);
        end while (!acc);
        sb.note_triangle(d);
    endtask

    function logic [W_TD_IN-1:0] pack_tri(int x1, int y1, int x2, int y2, int x3, int y3);
        return {y3, x3, y2, x2, y1, x1};
    endfunction

    function int rand_word();
        return int'($urandom());
    endfunction

    function logic [W_TD_IN-1:0] random_triangle();
        int cx, cy, sx, sy, kind;
        kind = $urandom_range(0, 9);
        cx = rand_word();
        cy = rand_word();
        case (kind)
            0, 1: return {rand_word(), rand_word(), rand_word(), rand_word(),
                          rand_word(), rand_word()};
            2: begin
                // collinear: third point on the line through the first two
                sx = $urandom_range(0, 4000) - 2000;
                sy = $urandom_range(0, 4000) - 2000;
                return pack_tri(cx, cy, cx + sx, cy + sy, cx - 3 * sx, cy - 3 * sy);
            end
            3: begin
                sx = rand_word();
                sy = rand_word();
                case ($urandom_range(0, 2))
                    0: return pack_tri(cx, cy, cx, cy, sx, sy);
                    1: return pack_tri(cx, cy, sx, sy, cx, cy);
                    default: return pack_tri(sx, sy, cx, cy, cx, cy);
                endcase
            end
            4, 5, 6: begin
                sx = 1 << $urandom_range(0, 20);
                return pack_tri(cx, cy,
                                cx + $urandom_range(0, 2 * sx) - sx,
                                cy + $urandom_range(0, 2 * sx) - sx,
                                cx + $urandom_range(0, 2 * sx) - sx,
                                cy + $urandom_range(0, 2 * sx) - sx);
            end
            default: begin
                cx = cx >>> $urandom_range(1, 16);
                cy = cy >>> $urandom_range(1, 16);
                sx = 1 << $urandom_range(16, 28);
                return pack_tri(cx, cy,
                                cx + int'($urandom_range(0, sx)),
                                cy + int'($urandom_range(0, sx)) / 4,
                                cx - int'($urandom_range(0, sx)) / 2,
                                cy + int'($urandom_range(0, sx)));
            end
        endcase
    endfunction

    // receiver
    initial begin
        int  gap;
        bit  acc;
        m_ready     = 1'b0;
        hold_active = 1'b0;
        results_seen = 0;
        wait (i_rst_n);
        forever begin
            if (results_seen == 300) begin
                // long stall so the pipeline fills and backs up the input
                hold_active <= 1'b1;
                m_ready     <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_active <= 1'b0;
            end else begin
                gap = (burst_mode && !hold_active) ? 0 : $urandom_range(0, 16);
                if (gap != 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            m_ready <= 1'b1;
            do begin
                @(negedge i_clk);
                acc = m_valid;
                if (acc) sb.check_circle(m_data, m_user);
                @(posedge i_clk);
            end while (!acc);
            results_seen++;
        end
    end

    // watchdog
    initial begin
        idle_cycles = 0;
        forever begin
            @(negedge i_clk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= 5000) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int mx, mn;
        sb           = new();
        burst_mode   = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        i_rst_n      = 1'b0;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_triangle(pack_tri(0, 0, 0, 0, 0, 0));
        send_triangle(pack_tri(0, 0, 65536, 0, 0, 65536));
        send_triangle(pack_tri(0, 0, 1, 0, 0, 1));
        send_triangle(pack_tri(mn, mn, mx, mn, mn, mx));
        send_triangle(pack_tri(mx, mx, mn, mx, mx, mn));
        send_triangle(pack_tri(mn, mn, mx, mx, mn, mx));
        send_triangle(pack_tri(mn, mn, mx, mx, 0, 0));
        send_triangle(pack_tri(mn, 0, mx, 0, 0, 1));
        send_triangle(pack_tri(0, mn, 0, mx, 1, 0));
        send_triangle(pack_tri(mn, mn, mn + 1, mn, mn, mn + 1));
        send_triangle(pack_tri(mx, mx, mx - 1, mx, mx, mx - 1));
        send_triangle(pack_tri(5, 7, 5, 7, 100, -3));
        send_triangle(pack_tri(1, 2, 3, 4, 5, 6));
        send_triangle(pack_tri(-65536, 0, 65536, 0, 0, 1));
        send_triangle(pack_tri(0, 0, 2, 0, 1, 1));
        send_triangle(pack_tri(0, 0, 3, 0, 0, 1));
        send_triangle(pack_tri(-1, -1, -1, -1, -1, -1));
        send_triangle(pack_tri(mx, mx, mx, mx, mn, mn));
        send_triangle(pack_tri(0, 0, mx, 1, 1, mx));
        send_triangle(pack_tri(-3, 5, 7, -2, 4, 9));

        for (int i = 0; i < 1350; i++) begin
            if (i % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            send_triangle(random_triangle());
        end
        s_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tcc_pkg.sv
rtl/triangle_circumcircle_top.sv
dv/tb_triangle_circumcircle_top.sv
